@@ sv/gtt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtt_pkg
// Types and constants of the graph text tokenizer: token kinds, scan modes,
// character codes and the result word.
// ----------------------------------------------------------------------------
package gtt_pkg;

   localparam int KIND_W   = 4;
   localparam int START_W  = 20;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;

   localparam logic [LEN_W-1:0] TOKEN_LENGTH_RESET = 6'd32;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LO_Z  = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_EQUAL = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
   localparam logic [BYTE_W-1:0] CH_END   = 8'hFF;

   typedef enum logic [KIND_W-1:0] {
      KIND_COMMA = 4'd0,
      KIND_EQUAL = 4'd1,
      KIND_OPEN  = 4'd2,
      KIND_CLOSE = 4'd3,
      KIND_IDENT = 4'd4,
      KIND_NUM   = 4'd5,
      KIND_END   = 4'd6,
      KIND_BAD   = 4'd7,
      KIND_LONG  = 4'd8
   } kind_type;

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_IDENT = 5'b00010,
      MODE_INT   = 5'b00100,
      MODE_FRAC  = 5'b01000,
      MODE_ERROR = 5'b10000
   } mode_type;

   typedef struct packed {
      kind_type               kind;
      logic [START_W-1:0]     start;
      logic [LEN_W-1:0]       length;
      logic                   last;
   } result_type;

   function automatic logic is_letter(input logic [BYTE_W-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

endpackage

@@ sv/graph_text_tokenizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_text_tokenizer
// Splits a stream of text bytes into comma, equals, brace, identifier and
// number tokens; reports bad symbols, over-long tokens and the end of text.
// ----------------------------------------------------------------------------
//  channel  dir   handshake            word
//  req_     in    req_valid/req_ready  text_byte, is_end
//  rsp_     out   rsp_valid/rsp_ready  token_kind, token_start, token_length,
//                                      last_of_run
//  csr_     in    csr_valid/csr_ready  max_token_length
//
//  one byte is accepted per cycle while req_ready is high; the scan state updates at acceptance and
//  the zero, one or two results go into a four-word result queue
//  a byte that gives two results fills two words of the result queue
//  req_ready drops only while the queue holds three or more words
//  reset (synchronous) empties the queue, clears the scan state and sets the
//  length limit to 32
// ----------------------------------------------------------------------------
module graph_text_tokenizer #(
   parameter int MAX_LEN     = 32,
   parameter int OFFSET_BITS = 20
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gtt_pkg::BYTE_W-1:0]    req_text_byte,
   input  logic                          req_is_end,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gtt_pkg::KIND_W-1:0]    rsp_token_kind,
   output logic [gtt_pkg::START_W-1:0]   rsp_token_start,
   output logic [gtt_pkg::LEN_W-1:0]     rsp_token_length,
   output logic                          rsp_last_of_run,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gtt_pkg::LEN_W-1:0]     csr_max_token_length
);

   localparam int START_W = gtt_pkg::START_W;
   localparam int LEN_W   = gtt_pkg::LEN_W;

   // state
   gtt_pkg::mode_type              mode_ff, mode_in;
   logic [OFFSET_BITS-1:0]         pstart_ff, pstart_in;
   logic [LEN_W-1:0]               plen_ff, plen_in;
   logic [OFFSET_BITS-1:0]         offset_ff, offset_in;
   logic [LEN_W-1:0]               max_len_ff;

   // result queue
   gtt_pkg::result_type            queue_ff [gtt_pkg::FIFO_DEPTH];
   logic [gtt_pkg::PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [gtt_pkg::PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [gtt_pkg::CNT_W-1:0]      count_ff, count_in;

   logic                           req_fire, rsp_fire;
   logic                           end_mark, pending, extend;
   logic [gtt_pkg::BYTE_W-1:0]     c;
   logic [LEN_W-1:0]               limit;
   logic [START_W+OFFSET_BITS-1:0] offset_wide, pstart_wide;
   logic [START_W-1:0]             offset_start, pstart_start;
   gtt_pkg::result_type            flush_word, second_word, slot0, slot1;
   logic                           flush_valid, second_valid;
   logic [1:0]                     push_count;

   assign csr_ready = 1'b1;
   assign req_ready = count_ff <= gtt_pkg::CNT_W'(gtt_pkg::FIFO_DEPTH - 2);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = count_ff != '0;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign c        = req_text_byte;
   assign end_mark = req_is_end || (c == gtt_pkg::CH_END);
   assign pending  = (mode_ff == gtt_pkg::MODE_IDENT) || (mode_ff == gtt_pkg::MODE_INT) ||
                     (mode_ff == gtt_pkg::MODE_FRAC);
   assign extend   = ((mode_ff == gtt_pkg::MODE_IDENT) &&
                      (gtt_pkg::is_letter(c) || gtt_pkg::is_digit(c))) ||
                     ((mode_ff == gtt_pkg::MODE_INT) &&
                      (gtt_pkg::is_digit(c) || c == gtt_pkg::CH_DOT)) ||
                     ((mode_ff == gtt_pkg::MODE_FRAC) && gtt_pkg::is_digit(c));

   // zero acts as one, anything above MAX_LEN as MAX_LEN
   always_comb begin
      if (max_len_ff == '0) begin
         limit = LEN_W'(1);
      end else if (max_len_ff > LEN_W'(MAX_LEN)) begin
         limit = LEN_W'(MAX_LEN);
      end else begin
         limit = max_len_ff;
      end
   end

   // offsets go out as their low START_W bits, zero extended if narrower
   assign offset_wide  = {{START_W{1'b0}}, offset_ff};
   assign pstart_wide  = {{START_W{1'b0}}, pstart_ff};
   assign offset_start = offset_wide[START_W-1:0];
   assign pstart_start = pstart_wide[START_W-1:0];

   always_comb begin
      mode_in      = mode_ff;
      pstart_in    = pstart_ff;
      plen_in      = plen_ff;
      offset_in    = offset_ff + OFFSET_BITS'(1);
      flush_valid  = 1'b0;
      second_valid = 1'b0;

      flush_word.kind   = (mode_ff == gtt_pkg::MODE_IDENT) ? gtt_pkg::KIND_IDENT :
                                                              gtt_pkg::KIND_NUM;
      flush_word.start  = pstart_start;
      flush_word.length = plen_ff;
      flush_word.last   = 1'b0;

      second_word.kind   = gtt_pkg::KIND_END;
      second_word.start  = offset_start;
      second_word.length = LEN_W'(1);
      second_word.last   = 1'b1;

      if (end_mark) begin
         flush_valid        = pending;
         second_valid       = 1'b1;
         second_word.length = '0;
         mode_in            = gtt_pkg::MODE_IDLE;
         pstart_in          = '0;
         plen_in            = '0;
         offset_in          = '0;
      end else if (mode_ff == gtt_pkg::MODE_ERROR) begin
         // bytes ignored until the end mark
      end else if (extend) begin
         if (plen_ff >= limit) begin
            second_valid       = 1'b1;
            second_word.kind   = gtt_pkg::KIND_LONG;
            second_word.start  = pstart_start;
            second_word.length = plen_ff;
            mode_in            = gtt_pkg::MODE_ERROR;
         end else begin
            plen_in = plen_ff + LEN_W'(1);
            if (mode_ff == gtt_pkg::MODE_INT && c == gtt_pkg::CH_DOT) begin
               mode_in = gtt_pkg::MODE_FRAC;
            end
         end
      end else begin
         if (pending) begin
            flush_valid = 1'b1;
            mode_in     = gtt_pkg::MODE_IDLE;
            plen_in     = '0;
         end
         if (c > gtt_pkg::CH_SPACE) begin
            second_valid = 1'b1;
            case (c)
               gtt_pkg::CH_COMMA: second_word.kind = gtt_pkg::KIND_COMMA;
               gtt_pkg::CH_EQUAL: second_word.kind = gtt_pkg::KIND_EQUAL;
               gtt_pkg::CH_OPEN:  second_word.kind = gtt_pkg::KIND_OPEN;
               gtt_pkg::CH_CLOSE: second_word.kind = gtt_pkg::KIND_CLOSE;
               default: begin
                  if (gtt_pkg::is_letter(c) || gtt_pkg::is_digit(c)) begin
                     second_valid = 1'b0;
                     mode_in      = gtt_pkg::is_letter(c) ? gtt_pkg::MODE_IDENT :
                                                            gtt_pkg::MODE_INT;
                     pstart_in    = offset_ff;
                     plen_in      = LEN_W'(1);
                  end else begin
                     second_word.kind = gtt_pkg::KIND_BAD;
                     mode_in          = gtt_pkg::MODE_ERROR;
                  end
               end
            endcase
         end
      end

      flush_word.last = !second_valid;
   end

   // pack the results into the queue slots in order
   always_comb begin
      slot0 = flush_valid ? flush_word : second_word;
      slot1 = second_word;
      if (req_fire) begin
         push_count = {1'b0, flush_valid} + {1'b0, second_valid};
      end else begin
         push_count = '0;
      end
      wr_ptr_in = wr_ptr_ff + gtt_pkg::PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + gtt_pkg::PTR_W'(rsp_fire);
      count_in  = count_ff + gtt_pkg::CNT_W'(push_count) - gtt_pkg::CNT_W'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= gtt_pkg::MODE_IDLE;
         pstart_ff  <= '0;
         plen_ff    <= '0;
         offset_ff  <= '0;
         max_len_ff <= gtt_pkg::TOKEN_LENGTH_RESET;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (req_fire) begin
            mode_ff   <= mode_in;
            pstart_ff <= pstart_in;
            plen_ff   <= plen_in;
            offset_ff <= offset_in;
         end
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_max_token_length;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_count == 2'd2) begin
         queue_ff[wr_ptr_ff + gtt_pkg::PTR_W'(1)] <= slot1;
      end
   end

   assign rsp_token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_token_start  = queue_ff[rd_ptr_ff].start;
   assign rsp_token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last;

endmodule
